>>> src/plg_pkg.sv
// ----------------------------------------------------------------------------
// plg_pkg
// Shared types and elaboration-time helpers for the pixel levels/gamma core.
// ----------------------------------------------------------------------------
package plg_pkg;

  // Per-word side data that travels with the word through every pipeline stage up to the output register
  typedef struct packed {
    logic        byp;   // identity settings: pass the sample unchanged
    logic [15:0] pix;   // masked input sample
    logic        fix;   // normalised value already settled
    logic [16:0] fv;    // settled normalised value, Q1.16
  } item_t;

  // Integer square root, used only at elaboration
  function automatic longint unsigned isqrt64(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    longint unsigned m;
    r = 0;
    b = 64'd1 << 62;
    m = n;
    while (b > m) b = b >> 2;
    while (b != 0) begin
      if (m >= r + b) begin
        m = m - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(-2^-(k+1)) in Q1.30, by repeated square roots
  function automatic logic [30:0] exp2_coef(input int k);
    longint unsigned c;
    int j;
    c = isqrt64(64'd1 << 59);
    for (j = 1; j <= k; j++) c = isqrt64(c << 30);
    return 31'(c);
  endfunction

endpackage

>>> src/pixel_levels_gamma_core.sv
// ----------------------------------------------------------------------------
// pixel_levels_gamma_core
// Levels adjustment of one pixel sample with gamma, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel : in_valid / in_stall / pixel_in, one sample per word.
//   Output channel: out_valid / out_stall / pixel_out, one sample per word.
//   Settings (in/out black and white levels, gamma in Q4.12) are written over
//   the APB port at byte addresses 0,4,8,12,16 while the core is idle; the
//   user must see to it, the core does not enforce it; they read back on prdata.
//   The pipe has 56 register stages, and one word is taken every cycle while
//   the pipe is not held. Depth is set by the 17-step normalising divider,
//   the 16 squaring stages of the log2 unit and the 16 multiply stages of
//   exp2, one multiplier per stage.
//   When the receiver stalls with a word waiting, the whole pipe holds and
//   in_stall is raised in the same cycle; nothing is dropped or repeated.
//   Reset clears every valid bit and loads the default settings (identity
//   mapping, gamma 1.0).
// ----------------------------------------------------------------------------
module pixel_levels_gamma_core #(
  parameter int PIXEL_BITS      = 16,
  parameter int GAMMA_FRAC_BITS = 12
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pixel_out
);
  import plg_pkg::*;

  localparam logic [2:0]  REG_IN_BLACK  = 3'd0;
  localparam logic [2:0]  REG_IN_WHITE  = 3'd1;
  localparam logic [2:0]  REG_OUT_BLACK = 3'd2;
  localparam logic [2:0]  REG_OUT_WHITE = 3'd3;
  localparam logic [2:0]  REG_GAMMA     = 3'd4;
  localparam logic [15:0] PMASK   = 16'((32'd1 << PIXEL_BITS) - 32'd1);
  localparam logic [16:0] GONE    = 17'(32'd1 << GAMMA_FRAC_BITS);
  localparam logic [37:0] GHALF   = 38'(64'd1 << (GAMMA_FRAC_BITS - 1));
  localparam logic [16:0] QONE    = 17'h10000;
  localparam logic [30:0] RONE    = 31'h4000_0000;
  localparam int          NDIV    = 17;
  localparam int          NSQ     = 16;
  localparam int          NEXP    = 16;

  // Settings registers
  logic [15:0] in_black, in_white, out_black, out_white, gamma_exp;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_black  <= 16'd0;
      in_white  <= 16'hFFFF;
      out_black <= 16'd0;
      out_white <= 16'hFFFF;
      gamma_exp <= 16'd4096;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_IN_BLACK:  in_black  <= pwdata[15:0];
        REG_IN_WHITE:  in_white  <= pwdata[15:0];
        REG_OUT_BLACK: out_black <= pwdata[15:0];
        REG_OUT_WHITE: out_white <= pwdata[15:0];
        REG_GAMMA:     gamma_exp <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    case (paddr[4:2])
      REG_IN_BLACK:  prdata = {16'd0, in_black};
      REG_IN_WHITE:  prdata = {16'd0, in_white};
      REG_OUT_BLACK: prdata = {16'd0, out_black};
      REG_OUT_WHITE: prdata = {16'd0, out_white};
      REG_GAMMA:     prdata = {16'd0, gamma_exp};
      default:       prdata = 32'd0;
    endcase
  end

  // Global advance: the pipe moves unless a finished word is held
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Masked levels, shared by the entry and output stages
  logic [15:0] ib, iw, ob, ow;
  logic        g_is_one;
  assign ib = in_black & PMASK;
  assign iw = in_white & PMASK;
  assign ob = out_black & PMASK;
  assign ow = out_white & PMASK;
  assign g_is_one = ({1'b0, gamma_exp} == GONE);

  // --------------------------------------------------------------------------
  // Entry stage and normalising divider: v = (n*2^17 + d) / (2d)
  // --------------------------------------------------------------------------
  logic        dv_v  [0:NDIV];
  item_t       dv_it [0:NDIV];
  logic [16:0] dv_r  [0:NDIV];
  logic [15:0] dv_d  [0:NDIV];
  logic [16:0] dv_q  [0:NDIV];

  item_t       a_it;
  logic [15:0] a_x, a_n, a_d;

  always_comb begin
    a_x        = pixel_in & PMASK;
    a_it.byp   = (ib == ob) && (iw == ow) && (ib == 16'd0) && (iw == PMASK) && g_is_one;
    a_it.pix   = a_x;
    a_it.fix   = 1'b0;
    a_it.fv    = 17'd0;
    a_n        = 16'd0;
    a_d        = 16'd0;
    if (ib == iw) begin
      // equal limits act as a threshold
      a_it.fix = 1'b1;
      a_it.fv  = (a_x >= ib) ? QONE : 17'd0;
    end else if (iw > ib) begin
      a_d = iw - ib;
      a_n = (a_x <= ib) ? 16'd0 : ((a_x >= iw) ? a_d : a_x - ib);
    end else begin
      a_d = ib - iw;
      a_n = (a_x >= ib) ? 16'd0 : ((a_x <= iw) ? a_d : ib - a_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0]  <= in_valid;
      dv_it[0] <= a_it;
      dv_r[0]  <= {1'b0, a_n};
      dv_d[0]  <= a_d;
      dv_q[0]  <= 17'd0;
    end
  end

  // One quotient bit per stage; the low dividend bits are d itself
  for (genvar j = 0; j < NDIV; j++) begin : g_div
    logic [16:0] dl;
    logic [17:0] t;
    logic [17:0] dd;
    logic        qb;
    always_comb begin
      dl = {1'b0, dv_d[j]};
      t  = {dv_r[j], dl[NDIV-1-j]};
      dd = {1'b0, dv_d[j], 1'b0};
      qb = (t >= dd);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[j+1] <= 1'b0;
      end else if (adv) begin
        dv_v[j+1]  <= dv_v[j];
        dv_it[j+1] <= dv_it[j];
        dv_d[j+1]  <= dv_d[j];
        dv_r[j+1]  <= qb ? 17'(t - dd) : t[16:0];
        dv_q[j+1]  <= {dv_q[j][15:0], qb};
      end
    end
  end

  // --------------------------------------------------------------------------
  // log2 front end: gamma special cases, leading-one and normalise to Q1.30
  // --------------------------------------------------------------------------
  logic        lg_v  [0:NSQ];
  item_t       lg_it [0:NSQ];
  logic [30:0] lg_x  [0:NSQ];
  logic [3:0]  lg_p  [0:NSQ];
  logic [15:0] lg_f  [0:NSQ];

  item_t       l_it;
  logic [16:0] l_vq;
  logic [3:0]  l_p;
  logic [30:0] l_x;

  always_comb begin
    l_vq = dv_it[NDIV].fix ? dv_it[NDIV].fv : dv_q[NDIV];
    l_p  = 4'd0;
    for (int b = 0; b < 16; b++) begin
      if (l_vq[b]) l_p = 4'(b);
    end
    l_x  = 31'({15'd0, l_vq[15:0]}) << (5'd30 - {1'b0, l_p});
    l_it = dv_it[NDIV];
    l_it.fix = 1'b1;
    if (g_is_one) begin
      l_it.fv = l_vq;
    end else if (gamma_exp == 16'd0) begin
      l_it.fv = QONE;
    end else if (l_vq == 17'd0) begin
      l_it.fv = 17'd0;
    end else if (l_vq >= QONE) begin
      l_it.fv = QONE;
    end else begin
      l_it.fix = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lg_v[0] <= 1'b0;
    end else if (adv) begin
      lg_v[0]  <= dv_v[NDIV];
      lg_it[0] <= l_it;
      lg_x[0]  <= l_x;
      lg_p[0]  <= l_p;
      lg_f[0]  <= 16'd0;
    end
  end

  // Squaring stages, one fraction bit of log2 each
  for (genvar k = 0; k < NSQ; k++) begin : g_sq
    logic [61:0] sq;
    logic [31:0] y;
    always_comb begin
      sq = 62'(lg_x[k]) * 62'(lg_x[k]);
      y  = sq[61:30];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        lg_v[k+1] <= 1'b0;
      end else if (adv) begin
        lg_v[k+1]  <= lg_v[k];
        lg_it[k+1] <= lg_it[k];
        lg_p[k+1]  <= lg_p[k];
        lg_x[k+1]  <= y[31] ? y[31:1] : y[30:0];
        lg_f[k+1]  <= {lg_f[k][14:0], y[31]};
      end
    end
  end

  // --------------------------------------------------------------------------
  // Product with gamma, then rounding and split into integer and fraction
  // --------------------------------------------------------------------------
  logic        qs_v;
  item_t       qs_it;
  logic [36:0] qs_prod;
  logic [20:0] q_val;

  assign q_val = {5'(5'd16 - {1'b0, lg_p[NSQ]}), 16'd0} - {5'd0, lg_f[NSQ]};

  always_ff @(posedge clk) begin
    if (rst) begin
      qs_v <= 1'b0;
    end else if (adv) begin
      qs_v    <= lg_v[NSQ];
      qs_it   <= lg_it[NSQ];
      qs_prod <= 37'(q_val) * 37'(gamma_exp);
    end
  end

  logic        ex_v  [0:NEXP];
  item_t       ex_it [0:NEXP];
  logic [30:0] ex_r  [0:NEXP];
  logic [15:0] ex_f  [0:NEXP];
  logic [4:0]  ex_i  [0:NEXP];

  logic [37:0] e_val;
  item_t       e_it;

  always_comb begin
    e_val = ({1'b0, qs_prod} + GHALF) >> GAMMA_FRAC_BITS;
    e_it  = qs_it;
    if (!qs_it.fix && (e_val[37:16] > 22'd16)) begin
      // underflow to zero
      e_it.fix = 1'b1;
      e_it.fv  = 17'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_v[0] <= 1'b0;
    end else if (adv) begin
      ex_v[0]  <= qs_v;
      ex_it[0] <= e_it;
      ex_r[0]  <= RONE;
      ex_f[0]  <= e_val[15:0];
      ex_i[0]  <= e_val[20:16];
    end
  end

  // --------------------------------------------------------------------------
  // exp2 of the negated fraction: one constant multiply per fraction bit
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NEXP; k++) begin : g_exp
    localparam logic [30:0] CK = exp2_coef(k);
    logic [61:0] pr;
    always_comb begin
      pr = 62'(ex_r[k]) * 62'(CK);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        ex_v[k+1] <= 1'b0;
      end else if (adv) begin
        ex_v[k+1]  <= ex_v[k];
        ex_it[k+1] <= ex_it[k];
        ex_f[k+1]  <= ex_f[k];
        ex_i[k+1]  <= ex_i[k];
        ex_r[k+1]  <= ex_f[k][NEXP-1-k] ? pr[60:30] : ex_r[k];
      end
    end
  end

  // Integer part of the exponent: rounded right shift back to Q1.16
  logic        fs_v;
  item_t       fs_it;
  logic [31:0] f_sum;
  logic [31:0] f_sh;
  item_t       f_it;

  always_comb begin
    f_sum = {1'b0, ex_r[NEXP]} + (32'd1 << (5'd13 + ex_i[NEXP]));
    f_sh  = f_sum >> (5'd14 + ex_i[NEXP]);
    f_it  = ex_it[NEXP];
    if (!f_it.fix) f_it.fv = f_sh[16:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fs_v <= 1'b0;
    end else if (adv) begin
      fs_v     <= ex_v[NEXP];
      fs_it    <= f_it;
    end
  end

  // --------------------------------------------------------------------------
  // Output scaling: multiply by the output span, then round and offset
  // --------------------------------------------------------------------------
  logic        ms_v;
  item_t       ms_it;
  logic [32:0] ms_m;
  logic        ms_up;
  logic [15:0] m_span;
  logic        m_up;

  assign m_up   = (ow >= ob);
  assign m_span = m_up ? ow - ob : ob - ow;

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_v <= 1'b0;
    end else if (adv) begin
      ms_v  <= fs_v;
      ms_it <= fs_it;
      ms_up <= m_up;
      ms_m  <= 33'(m_span) * 33'(fs_it.fv);
    end
  end

  logic [33:0] r_sum;
  logic [17:0] r_t;
  logic [17:0] r_res;

  always_comb begin
    r_sum = {1'b0, ms_m} + 34'd32768;
    r_t   = r_sum[33:16];
    r_res = ms_up ? {2'd0, ob} + r_t : {2'd0, ob} - r_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= ms_v;
      pixel_out <= ms_it.byp ? ms_it.pix : (r_res[15:0] & PMASK);
    end
  end

  // --------------------------------------------------------------------------
  // Checks
  // --------------------------------------------------------------------------
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (dv_v[NDIV] && !dv_it[NDIV].fix) |-> (dv_r[NDIV] < {dv_d[NDIV], 1'b0}))
    else $error("divider remainder not below divisor");

  a_log_norm: assert property (@(posedge clk) disable iff (rst)
    (lg_v[NSQ] && !lg_it[NSQ].fix) |-> lg_x[NSQ][30])
    else $error("log2 mantissa lost normalisation");

  a_exp_range: assert property (@(posedge clk) disable iff (rst)
    (ex_v[NEXP] && !ex_it[NEXP].fix) |-> (ex_r[NEXP] <= RONE))
    else $error("exp2 product above one");

  a_v_range: assert property (@(posedge clk) disable iff (rst)
    (fs_v && !fs_it.byp) |-> (fs_it.fv <= QONE))
    else $error("normalised value above one");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(ms_v))
    else $error("pipe moved while held");

endmodule

>>> sim/tb_pixel_levels_gamma_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_levels_gamma_core
// Self-checking bench for the levels/gamma core: settings are written over
// APB, samples are streamed with random gaps and output stalls, and every
// output word is compared against an in-bench fixed-point model.
// ----------------------------------------------------------------------------
module tb_pixel_levels_gamma_core;

  localparam int LATENCY  = 56;
  localparam int WDOG_MAX = 5000;

  localparam logic [4:0] A_IN_BLACK  = 5'd0;
  localparam logic [4:0] A_IN_WHITE  = 5'd4;
  localparam logic [4:0] A_OUT_BLACK = 5'd8;
  localparam logic [4:0] A_OUT_WHITE = 5'd12;
  localparam logic [4:0] A_GAMMA     = 5'd16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] pixel_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] pixel_out;

  // settings copy held by the bench
  logic [15:0] lvl_in_black = 16'd0, lvl_in_white = 16'hffff;
  logic [15:0] lvl_out_black = 16'd0, lvl_out_white = 16'hffff;
  logic [15:0] lvl_gamma = 16'd4096;

  logic [15:0] expected_pixels[$];
  longint unsigned exp2_tab[16];
  int  mismatches = 0;
  int  words_out = 0;
  int  words_in = 0;
  int  idle_cycles = 0;
  bit  stall_mode = 0;

  pixel_levels_gamma_core u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned norm_level(input longint unsigned x,
      input longint unsigned lo, input longint unsigned hi);
    longint unsigned d, n;
    if (lo == hi) return (x >= lo) ? 65536 : 0;
    if (hi > lo) begin
      d = hi - lo;
      n = (x <= lo) ? 0 : ((x >= hi) ? d : x - lo);
    end else begin
      d = lo - hi;
      n = (x >= lo) ? 0 : ((x <= hi) ? d : lo - x);
    end
    return (n * 2 * 65536 + d) / (2 * d);
  endfunction

  function automatic longint unsigned gamma_power(input longint unsigned v,
      input longint unsigned g);
    longint unsigned x, frac, q, e, r, ip;
    int p;
    if (g == 0) return 65536;
    if (v == 0) return 0;
    if (v >= 65536) return 65536;
    p = 0;
    frac = 0;
    while ((v >> (p + 1)) != 0) p++;
    x = v << (30 - p);
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      if (x >= (64'd1 << 31)) begin
        x = x >> 1;
        frac |= 64'd1 << (15 - i);
      end
    end
    q = (longint'(16 - p) << 16) - frac;
    e = (q * g + 2048) >> 12;
    ip = e >> 16;
    if (ip > 16) return 0;
    r = 64'd1 << 30;
    for (int k = 0; k < 16; k++)
      if ((e >> (15 - k)) & 1) r = (r * exp2_tab[k]) >> 30;
    return (r + (64'd1 << (13 + ip))) >> (14 + ip);
  endfunction

  function automatic logic [15:0] remap_pixel(input logic [15:0] px);
    longint unsigned v, t;
    if (lvl_in_black == 0 && lvl_out_black == 0 && lvl_in_white == 16'hffff &&
        lvl_out_white == 16'hffff && lvl_gamma == 16'd4096)
      return px;
    v = norm_level(px, lvl_in_black, lvl_in_white);
    if (lvl_gamma != 16'd4096) v = gamma_power(v, lvl_gamma);
    if (lvl_out_white >= lvl_out_black) begin
      t = ((lvl_out_white - lvl_out_black) * v + 32768) >> 16;
      return 16'(lvl_out_black + t);
    end
    t = ((lvl_out_black - lvl_out_white) * v + 32768) >> 16;
    return 16'(lvl_out_black - t);
  endfunction

  // ------------------------------------------------------------- checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      words_out++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", pixel_out);
      end else begin
        logic [15:0] want;
        want = expected_pixels.pop_front();
        if (pixel_out !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel_out mismatch: expected %h got %h", want, pixel_out);
        end
      end
    end
  end

  // receiver stall pattern; long runs without stalls in some phases
  always @(negedge clk) begin
    if (stall_mode) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  // watchdog on cycles with no accepted word
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else if (expected_pixels.size() != 0 || in_valid)
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_MAX) begin
      $display("[pixel_levels_gamma_core] ERROR");
      $finish;
    end
  end

  // ------------------------------------------------------------- drivers
  task automatic reg_write(input logic [4:0] addr, input logic [15:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= {16'h0, val};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      A_IN_BLACK:  lvl_in_black  = val;
      A_IN_WHITE:  lvl_in_white  = val;
      A_OUT_BLACK: lvl_out_black = val;
      A_OUT_WHITE: lvl_out_white = val;
      A_GAMMA:     lvl_gamma     = val;
      default: ;
    endcase
  endtask

  task automatic set_levels(input logic [15:0] ib, iw, ob, ow, g);
    reg_write(A_IN_BLACK, ib);
    reg_write(A_IN_WHITE, iw);
    reg_write(A_OUT_BLACK, ob);
    reg_write(A_OUT_WHITE, ow);
    reg_write(A_GAMMA, g);
  endtask

  // one sample, held until accepted; valid stays high for the caller to drop
  task automatic send_pixel(input logic [15:0] px);
    in_valid <= 1'b1;
    pixel_in <= px;
    expected_pixels = {expected_pixels, remap_pixel(px)};
    do @(posedge clk); while (in_stall);
    words_in++;
    @(negedge clk);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_burst(input int count, input bit gaps);
    int run;
    int gap;
    while (count > 0) begin
      run = gaps ? $urandom_range(1, 12) : count;
      while (run > 0 && count > 0) begin
        send_pixel(16'($urandom));
        run--; count--;
      end
      gap = gaps ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_identity_extremes;
    logic [15:0] pts[6] = '{16'h0000, 16'hffff, 16'h0001, 16'h8000, 16'haaaa, 16'h5555};
    foreach (pts[i]) send_pixel(pts[i]);
    drain();
  endtask

  task automatic test_special_settings;
    // equal limits threshold, gamma zero, reversed mapping with high gamma, tiny gamma
    set_levels(16'h4000, 16'h4000, 16'd0, 16'hffff, 16'd4096);
    send_pixel(16'h3fff); send_pixel(16'h4000); send_pixel(16'hffff);
    drain();
    set_levels(16'h1000, 16'hf000, 16'h0100, 16'hff00, 16'd0);
    send_pixel(16'h0000); send_pixel(16'h8000); send_pixel(16'hffff);
    drain();
    set_levels(16'hffff, 16'h0000, 16'hffff, 16'h0000, 16'hffff);
    send_pixel(16'h0000); send_pixel(16'h0001); send_pixel(16'h7fff);
    send_pixel(16'hfffe); send_pixel(16'hffff);
    drain();
    set_levels(16'd0, 16'hffff, 16'd0, 16'hffff, 16'd1);
    send_pixel(16'h0001); send_pixel(16'hc000); send_pixel(16'hffff);
    drain();
  endtask

  task automatic test_random_phases;
    logic [15:0] g;
    for (int ph = 0; ph < 14; ph++) begin
      case ($urandom_range(0, 3))
        0: g = 16'd4096;
        1: g = 16'($urandom_range(1024, 12288));
        2: g = 16'($urandom);
        default: g = 16'($urandom_range(0, 16));
      endcase
      if (ph == 0) set_levels(16'd0, 16'hffff, 16'd0, 16'hffff, 16'd4096);
      else set_levels(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), g);
      stall_mode = (ph % 3 != 0);
      send_burst(130, (ph % 4 != 1));
      drain();
    end
    stall_mode = 0;
  endtask

  initial begin
    for (int k = 0; k < 16; k++)
      exp2_tab[k] = (k == 0) ? int_sqrt(64'd1 << 59) : int_sqrt(exp2_tab[k-1] << 30);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_identity_extremes();
    test_special_settings();
    test_random_phases();
    $display("Streamed %0d samples, checked %0d words over identity, threshold,",
             words_in, words_out);
    $display("gamma-zero, reversed and random level/gamma settings with stalls.");
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("[pixel_levels_gamma_core] OK");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, expected_pixels.size());
      $display("[pixel_levels_gamma_core] ERROR");
    end
    $finish;
  end

endmodule
